// File: hdl/assert_macros.svh
// Assertion macros used by the top level RTL file of the match buffer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication check sampled on the rising clock, off while reset is low.
`define ASSERT_IMPLY(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// File: hdl/trmb_pkg.sv
// Types and codes of the tagged response match buffer.
`default_nettype none
package trmb_pkg;

    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int ID_W     = 16;
    localparam int DATA_W   = 32;

    // request operation codes
    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_GET   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // response status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ID_W-1:0]   request_id;
        logic [DATA_W-1:0] payload;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   payload_out;
    } t_resp;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic put_step;
        logic get_step;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              put_end;
        logic              get_end;
        logic              out_free;
    } t_stat;

endpackage
`default_nettype wire

// File: hdl/trmb_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module trmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: hdl/trmb_ctrl.sv
// Controller state machine of the match buffer.
`default_nettype none
module trmb_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req_valid,
    output logic                o_req_ready,
    input  wire trmb_pkg::t_stat i_stat,
    output trmb_pkg::t_cmd      o_cmd
);
    import trmb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PUT  = 4'b0010,
        S_GET  = 4'b0100,
        S_HOLD = 4'b1000
    } t_state;

    t_state r_state, n_state;

    assign o_req_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_stat.func)
                        FUNC_PUT: n_state = S_PUT;
                        FUNC_GET: n_state = S_GET;
                        default:  n_state = S_HOLD;
                    endcase
                end
            end
            S_PUT: begin
                o_cmd.put_step = 1'b1;
                if (i_stat.put_end) n_state = S_HOLD;
            end
            S_GET: begin
                o_cmd.get_step = 1'b1;
                if (i_stat.get_end) n_state = S_HOLD;
            end
            S_HOLD: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// File: hdl/trmb_dp.sv
// Datapath of the match buffer: slot store, valid bits, pointers, scan and output register.
`default_nettype none
module trmb_dp #(
    parameter int DEPTH = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire trmb_pkg::t_req  i_req,
    input  wire trmb_pkg::t_cmd  i_cmd,
    output trmb_pkg::t_stat      o_stat,
    output logic                 o_resp_valid,
    input  wire logic            i_resp_ready,
    output trmb_pkg::t_resp      o_resp
);
    import trmb_pkg::*;

    localparam int AW     = $clog2(DEPTH);
    localparam int WORD_W = ID_W + DATA_W;
    localparam logic [AW-1:0] IDX_LAST = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx);
        return (idx == IDX_LAST) ? '0 : idx + 1'b1;
    endfunction

    t_req             r_req;
    logic [DEPTH-1:0] r_valid;
    logic [AW-1:0]    r_ins_ptr;
    logic [AW-1:0]    r_srch_ptr;
    logic [AW-1:0]    r_idx;
    logic [AW-1:0]    r_cnt;
    logic             r_iss_done;
    logic             r_cmp_live;
    logic             r_cmp_last;
    logic [AW-1:0]    r_cmp_idx;
    t_resp            r_res;
    t_resp            r_out;
    logic             r_out_valid;

    logic              put_empty;
    logic              put_end;
    logic              get_hit;
    logic              get_miss;
    logic              ram_we;
    logic [WORD_W-1:0] ram_rd;
    logic [ID_W-1:0]   ram_id;
    logic [DATA_W-1:0] ram_pay;

    // slot id and payload store
    trmb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_idx),
        .i_wr_data ({r_req.request_id, r_req.payload}),
        .i_rd_en   (i_cmd.get_step),
        .i_rd_addr (r_idx),
        .o_rd_data (ram_rd)
    );

    assign ram_id  = ram_rd[DATA_W +: ID_W];
    assign ram_pay = ram_rd[DATA_W-1:0];

    // put: one slot checked per cycle
    assign put_empty = !r_valid[r_idx];
    assign put_end   = put_empty || (r_cnt == IDX_LAST);
    assign ram_we    = i_cmd.put_step && put_empty;

    // get: compare stage works in the cycle after its read address is issued
    assign get_hit  = r_cmp_live && r_valid[r_cmp_idx] && (ram_id == r_req.request_id);
    assign get_miss = r_cmp_live && r_cmp_last && !get_hit;

    always_comb begin
        o_stat.func     = i_req.func;
        o_stat.put_end  = put_end;
        o_stat.get_end  = get_hit || get_miss;
        o_stat.out_free = !r_out_valid || i_resp_ready;
    end

    assign o_resp_valid = r_out_valid;
    assign o_resp       = r_out;

    // control state: valid bits, pointers, scan flags, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_ins_ptr   <= '0;
            r_srch_ptr  <= '0;
            r_iss_done  <= 1'b0;
            r_cmp_live  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_iss_done <= 1'b0;
                r_cmp_live <= 1'b0;
                if (i_req.func == FUNC_CLEAR) begin
                    r_valid    <= '0;
                    r_ins_ptr  <= '0;
                    r_srch_ptr <= '0;
                end
            end
            if (i_cmd.put_step && put_empty) begin
                r_valid[r_idx] <= 1'b1;
                r_ins_ptr      <= next_slot(r_idx);
            end
            if (i_cmd.get_step) begin
                r_cmp_live <= !r_iss_done;
                if (!r_iss_done && (r_cnt == IDX_LAST)) r_iss_done <= 1'b1;
                if (get_hit) begin
                    r_valid[r_cmp_idx] <= 1'b0;
                    r_srch_ptr         <= next_slot(r_cmp_idx);
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_resp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: request copy, scan index, result and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req             <= i_req;
            r_cnt             <= '0;
            r_res.status      <= ST_DONE;
            r_res.payload_out <= '0;
            r_idx             <= (i_req.func == FUNC_GET) ? r_srch_ptr : r_ins_ptr;
        end
        if (i_cmd.put_step) begin
            if (!put_empty) begin
                r_idx <= next_slot(r_idx);
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == IDX_LAST) r_res.status <= ST_FULL;
            end
        end
        if (i_cmd.get_step) begin
            if (!r_iss_done) begin
                r_cmp_idx  <= r_idx;
                r_cmp_last <= (r_cnt == IDX_LAST);
                r_idx      <= next_slot(r_idx);
                r_cnt      <= r_cnt + 1'b1;
            end
            if (get_hit) begin
                r_res.status      <= ST_DONE;
                r_res.payload_out <= ram_pay;
            end else if (get_miss) begin
                r_res.status <= ST_NOT_FOUND;
            end
        end
        if (i_cmd.emit) begin
            r_out <= r_res;
        end
    end

endmodule
`default_nettype wire

// File: hdl/tagged_response_match_buffer.sv
// Tagged response match buffer, top level.
//
// Request channel (i_req_valid / o_req_ready / i_req): func selects put (store
// request_id and payload in the first empty slot from the insert pointer), get
// (find and free the first valid slot with a matching id from the search
// pointer) or clear (empty all slots, rewind both pointers).
// Response channel (o_resp_valid / i_resp_ready / o_resp): one response per
// request, with status done, full or not found, and the payload of a get.
// A request is taken only while the controller is idle; one is worked on at a
// time. A put checks one slot per cycle. A get reads one slot per cycle from
// the slot RAM, with the id compare in the cycle after the read. Clear and
// unused codes go to the output stage without a scan. The controller returns
// to idle as a response is loaded into the output register, so the next
// request is accepted also while that response still waits.
// When the receiver stalls, a finished result waits in the datapath result
// register, with the controller holding, until the output register frees up.
// Synchronous active-low reset empties all slots, zeroes both pointers and
// drops o_resp_valid; slot RAM contents are not cleared.
`default_nettype none
`include "assert_macros.svh"
module tagged_response_match_buffer #(
    parameter int DEPTH = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    output logic                 o_req_ready,
    input  wire trmb_pkg::t_req  i_req,
    output logic                 o_resp_valid,
    input  wire logic            i_resp_ready,
    output trmb_pkg::t_resp      o_resp
);
    import trmb_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    trmb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    trmb_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_resp_valid (o_resp_valid),
        .i_resp_ready (i_resp_ready),
        .o_resp       (o_resp)
    );

    // no scan or emit while a new request can be taken
    `ASSERT_NEVER(a_ready_busy, i_clk, i_rst_n, o_req_ready && (cmd.put_step || cmd.get_step || cmd.emit), "ready while busy")
    // a waiting response is never overwritten
    `ASSERT_IMPLY(a_emit_free, i_clk, i_rst_n, cmd.emit |-> (!o_resp_valid || i_resp_ready), "response overwritten")
    // an emitted result shows up on the response channel
    `ASSERT_IMPLY(a_emit_valid, i_clk, i_rst_n, cmd.emit |=> o_resp_valid, "response lost")

endmodule
`default_nettype wire
